[hdl/cfsh_pkg.sv]
// ============================================================================
// cfsh_pkg: shared constants and functions for the case-folded string hash
// Seed reset value, finalization constants, S-box table, absorb and finish.
// ============================================================================
package cfsh_pkg;

    localparam int unsigned HASH_W = 32;
    localparam int unsigned BYTE_W = 8;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [BYTE_W-1:0] byte_t;

    localparam hash_t SEED_RESET = 32'h4A53_C5A7;
    localparam hash_t FIN_XOR    = 32'hDEAD_BEEF;
    localparam int unsigned ABS_SHL = 7;
    localparam int unsigned ABS_SHR = 3;
    localparam int unsigned FIN_SHL = 21;
    localparam int unsigned FIN_SHR = 12;

    localparam byte_t LOWER_A   = 8'h61;
    localparam byte_t LOWER_Z   = 8'h7A;
    localparam byte_t CASE_BIT  = 8'h20;

    // AES forward substitution table
    localparam byte_t SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Fold a-z to upper case, sign-extend, then shift-add into the hash
    function automatic hash_t absorb(input hash_t h, input byte_t b);
        byte_t f;
        hash_t c;
        f = b;
        if (b >= LOWER_A && b <= LOWER_Z)
        begin
            f = b & ~CASE_BIT;
        end
        c = {{(HASH_W-BYTE_W){f[BYTE_W-1]}}, f};
        return (h << ABS_SHL) + (h >> ABS_SHR) + c;
    endfunction

    // Final mix followed by a per-byte S-box pass
    function automatic hash_t finish(input hash_t h);
        hash_t x;
        hash_t y;
        hash_t z;
        hash_t r;
        x = h ^ FIN_XOR;
        y = ~x + (x << FIN_SHL);
        z = y ^ (y >> FIN_SHR);
        for (int i = 0; i < HASH_W / BYTE_W; i++)
        begin
            r[i*BYTE_W +: BYTE_W] = SBOX[z[i*BYTE_W +: BYTE_W]];
        end
        return r;
    endfunction

endpackage

[hdl/case_folded_string_hash_core.sv]
// ============================================================================
// case_folded_string_hash_core: streaming case-folded name hash
// Running shift-add hash per name, finalized and S-box mapped on the last word.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one name byte per word (tdata), tlast marks the
//   final word of a name, tuser flags a word with no character (used to
//   close an empty name). Each character word updates the running hash
//   when accepted; a tlast word closes the name and produces one output
//   word holding the 32-bit finalized hash. Other words give no output.
//   Throughput: one input word per cycle while the receiver keeps up.
//   A tlast word loads the finalize stage at its accepting edge; the output
//   register loads from the finalize stage once it is empty or being taken,
//   and the hash is then valid until the receiver takes it.
//   The shift-add update of the running hash is the only loop-carried path;
//   finalization and the S-box lookup sit in their own pipeline stage.
//   When the receiver stalls, the output word holds; one more finished
//   hash can wait in the finalize stage, after which tready drops.
//   Reset clears both stages and loads the seed register and running hash
//   with 0x4A53C5A7. A seed write takes effect after the next tlast word.
// ============================================================================
module case_folded_string_hash_core
    import cfsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // seed register write
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] name_byte
    input  logic        s_axis_tlast,   // is_last
    input  logic        s_axis_tuser,   // [0] no_char
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] hash_value
);

    hash_t seed_reg;
    hash_t run_hash_reg;
    hash_t run_hash_next;
    hash_t absorbed;
    logic  pend_valid_reg;
    hash_t pend_hash_reg;
    logic  out_valid_reg;
    hash_t out_hash_reg;
    logic  s_accept;
    logic  out_load;
    logic  pend_load;

    // Handshake: output register frees when taken, finalize stage drains into it
    assign out_load      = pend_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !pend_valid_reg || out_load;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign pend_load     = s_accept && s_axis_tlast;

    // Running hash update
    always_comb
    begin
        absorbed = s_axis_tuser ? run_hash_reg : absorb(run_hash_reg, s_axis_tdata);
        run_hash_next = s_axis_tlast ? seed_reg : absorbed;
    end

    // Seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_wr_en)
        begin
            seed_reg <= cfg_wr_data;
        end
    end

    // Running hash register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_hash_reg <= SEED_RESET;
        end
        else if (s_accept)
        begin
            run_hash_reg <= run_hash_next;
        end
    end

    // Finalize stage: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (pend_load)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    // Finalize stage: unmixed hash of the closed name
    always_ff @(posedge clk)
    begin
        if (pend_load)
        begin
            pend_hash_reg <= absorbed;
        end
    end

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: final mix and S-box
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hash_reg <= finish(pend_hash_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_hash_reg;

    // Checks
    a_ready_only_blocked_by_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> pend_valid_reg)
        else $error("tready low with finalize stage empty");

    a_last_fills_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_load |=> pend_valid_reg)
        else $error("closed name lost before finalize stage");

    a_last_reloads_seed: assert property (@(posedge clk) disable iff (!rst_n)
        pend_load |=> (run_hash_reg == $past(seed_reg)))
        else $error("running hash not reseeded after last word");

    a_empty_word_holds_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_axis_tuser && !s_axis_tlast) |=> $stable(run_hash_reg))
        else $error("word without character changed running hash");

    a_pending_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("finalized hash did not reach output register");

endmodule
